>>> sv/dcr_pkg.sv
// Shared types, register codes, widths, rounding and saturation helpers for the disc
// collision response block. No dependencies.
package dcr_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 1'b1;

	localparam logic [14:0] RESTITUTION_RST = 15'd13107;
	localparam logic [15:0] TIME_STEP_RST   = 16'd655;

	localparam logic [15:0] ONE_Q14 = 16'd16384;
	localparam logic [16:0] ONE_Q12 = 17'd4096;

	// long divider geometry: quotient bits, numerator and divisor widths
	localparam int DIV_STEPS = 32;
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 36;

	typedef struct packed {
		logic signed [15:0] a_pos_x;
		logic signed [15:0] a_pos_y;
		logic signed [15:0] a_vel_x;
		logic signed [15:0] a_vel_y;
		logic signed [15:0] b_pos_x;
		logic signed [15:0] b_pos_y;
		logic signed [15:0] b_vel_x;
		logic signed [15:0] b_vel_y;
		logic [15:0]        mass_b_rel;
		logic [14:0]        contact_dist;
	} pair_t;

	typedef struct packed {
		logic signed [15:0] new_a_vel_x;
		logic signed [15:0] new_a_vel_y;
		logic signed [15:0] new_b_vel_x;
		logic signed [15:0] new_b_vel_y;
		logic signed [15:0] new_a_pos_x;
		logic signed [15:0] new_a_pos_y;
		logic signed [15:0] new_b_pos_x;
		logic signed [15:0] new_b_pos_y;
		logic               stepped_back;
		logic               coincident;
	} resp_t;

	// item context carried down the pipeline
	typedef struct packed {
		pair_t              pr;
		logic signed [15:0] sb_a_x;
		logic signed [15:0] sb_a_y;
		logic signed [15:0] sb_b_x;
		logic signed [15:0] sb_b_y;
		logic signed [15:0] nv_a_x;
		logic signed [15:0] nv_a_y;
		logic signed [15:0] nv_b_x;
		logic signed [15:0] nv_b_y;
		logic               neg_x;
		logic               neg_y;
		logic               coin;
	} carry_t;

	// v / 2^n, nearest, ties away from zero; n >= 1
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int unsigned n);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (n - 1))) >> n;
		rnd_shr = v[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (v < -64'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = 16'(v);
		end
	endfunction

endpackage

>>> sv/dcr_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on dcr_pkg for its widths; numerator must be below den * 2^DIV_STEPS.
module dcr_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [dcr_pkg::DIV_NUM_W-1:0] num,
	input  logic [dcr_pkg::DIV_DEN_W-1:0] den,
	output logic [dcr_pkg::DIV_STEPS-1:0] quo
);

	logic [dcr_pkg::DIV_DEN_W-1:0] rem_s [dcr_pkg::DIV_STEPS-1];
	logic [dcr_pkg::DIV_DEN_W-1:0] den_s [dcr_pkg::DIV_STEPS-1];
	logic [dcr_pkg::DIV_STEPS-1:0] low_s [dcr_pkg::DIV_STEPS-1];
	logic [dcr_pkg::DIV_STEPS-1:0] quo_s [dcr_pkg::DIV_STEPS];

	for (genvar g = 0; g < dcr_pkg::DIV_STEPS; g++) begin : g_step
		logic [dcr_pkg::DIV_DEN_W-1:0] cur_rem;
		logic [dcr_pkg::DIV_DEN_W-1:0] cur_den;
		logic [dcr_pkg::DIV_STEPS-1:0] cur_low;
		logic [dcr_pkg::DIV_STEPS-1:0] cur_quo;
		logic [dcr_pkg::DIV_DEN_W:0]   trial;
		logic                          take;

		if (g == 0) begin : g_first
			assign cur_rem = dcr_pkg::DIV_DEN_W'(num[dcr_pkg::DIV_NUM_W-1:dcr_pkg::DIV_STEPS]);
			assign cur_low = num[dcr_pkg::DIV_STEPS-1:0];
			assign cur_quo = '0;
			assign cur_den = den;
		end else begin : g_next
			assign cur_rem = rem_s[g-1];
			assign cur_low = low_s[g-1];
			assign cur_quo = quo_s[g-1];
			assign cur_den = den_s[g-1];
		end

		assign trial = {cur_rem, cur_low[dcr_pkg::DIV_STEPS-1]};
		assign take  = trial >= {1'b0, cur_den};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[g] <= {cur_quo[dcr_pkg::DIV_STEPS-2:0], take};
			end
		end

		if (g < dcr_pkg::DIV_STEPS - 1) begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= take ? dcr_pkg::DIV_DEN_W'(trial - {1'b0, cur_den})
						: dcr_pkg::DIV_DEN_W'(trial);
					low_s[g] <= cur_low << 1;
					den_s[g] <= cur_den;
				end
			end
		end
	end

	assign quo = quo_s[dcr_pkg::DIV_STEPS-1];

endmodule

>>> sv/disc_collision_response.sv
// Top level: two-disc collision response with restitution, deep pipeline.
// Depends on dcr_pkg and dcr_div (four long dividers).
//
//  channel | direction | words                 | handshake
//  pair    | in        | pair_t, one disc pair | pair_valid / pair_ready
//  resp    | out       | resp_t, one result    | resp_valid / resp_ready
//  cfg     | in        | index + 16-bit data   | cfg_valid / cfg_ready
//
// One pair enters per cycle while resp is not stalled; each word passes
// through the bit-per-stage dividers for the mass factors and the normal
// projection. cfg is always ready and takes effect at once.
// Reset clears the valid bits and loads the register defaults. A stall on
// resp holds every stage together; pair_ready drops only while the last
// stage holds a word that is not taken.
module disc_collision_response (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pair_valid,
	output logic                           pair_ready,
	input  dcr_pkg::pair_t                 pair,
	output logic                           resp_valid,
	input  logic                           resp_ready,
	output dcr_pkg::resp_t                 resp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NS = dcr_pkg::DIV_STEPS;

	logic [14:0]        restitution_q;
	logic [15:0]        time_step_q;
	logic [15:0]        e1;
	logic signed [16:0] dts;
	logic               en;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_line_s [NS];

	// stage 1
	dcr_pkg::pair_t     pair_s1;
	logic signed [16:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic               coin_s1;
	// stage 2
	dcr_pkg::pair_t     pair_s2;
	logic signed [16:0] dx_s2, dy_s2;
	logic               coin_s2;
	logic [32:0]        dxx_s2, dyy_s2;
	logic signed [33:0] rx_s2, ry_s2;
	logic signed [32:0] mv_ax_s2, mv_ay_s2, mv_bx_s2, mv_by_s2;
	logic signed [33:0] sq_dx, sq_dy, rx_c, ry_c;
	logic signed [32:0] mv_ax_c, mv_ay_c, mv_bx_c, mv_by_c;
	// stage 3
	dcr_pkg::carry_t    cr3_c, carry_s3;
	logic [33:0]        dd_s3;
	logic signed [34:0] rel_s3;
	logic signed [16:0] dx_s3, dy_s3;
	// stage 4
	dcr_pkg::carry_t    carry_s4;
	logic signed [51:0] px_c, py_c, px_s4, py_s4;
	logic [33:0]        dd_s4;
	logic [31:0]        ke1_c, ke1_s4;
	// stage 5: divider inputs
	dcr_pkg::carry_t    cr5_c, carry_s5;
	logic [50:0]        pxm, pym;
	logic [16:0]        den_c, den_s5;
	logic [63:0]        num_x_s5, num_y_s5, fan_s5, fbn_s5;
	logic [33:0]        dd_s5;
	// divider line
	dcr_pkg::carry_t    div_line_s [NS];
	logic [NS-1:0]      q_fa, q_fb, q_wx, q_wy;
	// stage 6
	dcr_pkg::carry_t    carry_s6;
	logic signed [18:0] wmx, wmy, wx, wy;
	logic signed [32:0] fa_c, fb_c;
	logic signed [51:0] pax_c, pay_c, pbx_c, pby_c;
	logic signed [51:0] pax_s6, pay_s6, pbx_s6, pby_s6;
	// stage 7..10
	dcr_pkg::carry_t    cr7_c, carry_s7, carry_s8, carry_s9, carry_s10;
	logic signed [16:0] dvx_c, dvy_c;
	logic signed [33:0] tx_c, ty_c, tx_s8, ty_s8;
	logic signed [18:0] sepx_s9, sepy_s9;
	logic signed [37:0] sx2_c, sy2_c;
	logic [36:0]        sx2_s10, sy2_s10;
	logic [29:0]        c2_s10;
	// output
	logic               back;
	dcr_pkg::resp_t     resp_s11;

	assign e1  = 16'(restitution_q) + dcr_pkg::ONE_Q14;
	assign dts = $signed({1'b0, time_step_q});
	assign en  = !v_s11 || resp_ready;

	assign pair_ready = en;
	assign cfg_ready  = 1'b1;
	assign resp_valid = v_s11;
	assign resp       = resp_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= dcr_pkg::RESTITUTION_RST;
			time_step_q   <= dcr_pkg::TIME_STEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dcr_pkg::REG_RESTITUTION: restitution_q <= cfg_data[14:0];
				dcr_pkg::REG_TIME_STEP:   time_step_q   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < NS; i++) begin
				v_line_s[i] <= 1'b0;
			end
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_line_s[0] <= v_s5;
			for (int i = 1; i < NS; i++) begin
				v_line_s[i] <= v_line_s[i-1];
			end
			v_s6  <= v_line_s[NS-1];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// stage 1: centre and velocity differences
	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= pair;
			dx_s1   <= 17'(pair.b_pos_x) - 17'(pair.a_pos_x);
			dy_s1   <= 17'(pair.b_pos_y) - 17'(pair.a_pos_y);
			dvx_s1  <= 17'(pair.b_vel_x) - 17'(pair.a_vel_x);
			dvy_s1  <= 17'(pair.b_vel_y) - 17'(pair.a_vel_y);
			coin_s1 <= (pair.a_pos_x == pair.b_pos_x) && (pair.a_pos_y == pair.b_pos_y);
		end
	end

	// stage 2: squares, relative-velocity products, step-back products
	assign sq_dx   = dx_s1 * dx_s1;
	assign sq_dy   = dy_s1 * dy_s1;
	assign rx_c    = dvx_s1 * dx_s1;
	assign ry_c    = dvy_s1 * dy_s1;
	assign mv_ax_c = pair_s1.a_vel_x * dts;
	assign mv_ay_c = pair_s1.a_vel_y * dts;
	assign mv_bx_c = pair_s1.b_vel_x * dts;
	assign mv_by_c = pair_s1.b_vel_y * dts;

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s2  <= pair_s1;
			dx_s2    <= dx_s1;
			dy_s2    <= dy_s1;
			coin_s2  <= coin_s1;
			dxx_s2   <= sq_dx[32:0];
			dyy_s2   <= sq_dy[32:0];
			rx_s2    <= rx_c;
			ry_s2    <= ry_c;
			mv_ax_s2 <= mv_ax_c;
			mv_ay_s2 <= mv_ay_c;
			mv_bx_s2 <= mv_bx_c;
			mv_by_s2 <= mv_by_c;
		end
	end

	// stage 3: |d|^2, (vB-vA).d, stepped-back positions
	always_comb begin
		cr3_c        = '0;
		cr3_c.pr     = pair_s2;
		cr3_c.coin   = coin_s2;
		cr3_c.sb_a_x = dcr_pkg::sat16(64'(pair_s2.a_pos_x) - dcr_pkg::rnd_shr(64'(mv_ax_s2), 16));
		cr3_c.sb_a_y = dcr_pkg::sat16(64'(pair_s2.a_pos_y) - dcr_pkg::rnd_shr(64'(mv_ay_s2), 16));
		cr3_c.sb_b_x = dcr_pkg::sat16(64'(pair_s2.b_pos_x) - dcr_pkg::rnd_shr(64'(mv_bx_s2), 16));
		cr3_c.sb_b_y = dcr_pkg::sat16(64'(pair_s2.b_pos_y) - dcr_pkg::rnd_shr(64'(mv_by_s2), 16));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s3 <= cr3_c;
			dd_s3    <= 34'(dxx_s2) + 34'(dyy_s2);
			rel_s3   <= 35'(rx_s2) + 35'(ry_s2);
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
		end
	end

	// stage 4: projection numerators and K*(1+E)
	assign px_c  = rel_s3 * dx_s3;
	assign py_c  = rel_s3 * dy_s3;
	assign ke1_c = carry_s3.pr.mass_b_rel * e1;

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s4 <= carry_s3;
			px_s4    <= px_c;
			py_s4    <= py_c;
			dd_s4    <= dd_s3;
			ke1_s4   <= ke1_c;
		end
	end

	// stage 5: magnitudes plus half divisor for round-to-nearest
	assign pxm   = px_s4[51] ? 51'(-px_s4) : 51'(px_s4);
	assign pym   = py_s4[51] ? 51'(-py_s4) : 51'(py_s4);
	assign den_c = 17'(carry_s4.pr.mass_b_rel) + dcr_pkg::ONE_Q12;

	always_comb begin
		cr5_c       = carry_s4;
		cr5_c.neg_x = px_s4[51];
		cr5_c.neg_y = py_s4[51];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s5 <= cr5_c;
			num_x_s5 <= 64'(pxm) + 64'(dd_s4[33:1]);
			num_y_s5 <= 64'(pym) + 64'(dd_s4[33:1]);
			dd_s5    <= dd_s4;
			den_s5   <= den_c;
			fan_s5   <= {16'd0, ke1_s4, 16'd0} + 64'(den_c[16:1]);
			fbn_s5   <= (64'(e1) << 28) + 64'(den_c[16:1]);
		end
	end

	dcr_div u_div_fa (
		.clk (clk),
		.en  (en),
		.num (fan_s5),
		.den (dcr_pkg::DIV_DEN_W'(den_s5)),
		.quo (q_fa)
	);

	dcr_div u_div_fb (
		.clk (clk),
		.en  (en),
		.num (fbn_s5),
		.den (dcr_pkg::DIV_DEN_W'(den_s5)),
		.quo (q_fb)
	);

	dcr_div u_div_wx (
		.clk (clk),
		.en  (en),
		.num (num_x_s5),
		.den (dcr_pkg::DIV_DEN_W'(dd_s5)),
		.quo (q_wx)
	);

	dcr_div u_div_wy (
		.clk (clk),
		.en  (en),
		.num (num_y_s5),
		.den (dcr_pkg::DIV_DEN_W'(dd_s5)),
		.quo (q_wy)
	);

	// hold item context alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			div_line_s[0] <= carry_s5;
			for (int i = 1; i < NS; i++) begin
				div_line_s[i] <= div_line_s[i-1];
			end
		end
	end

	// stage 6: velocity changes f * w; |w| stays below 2^17
	assign wmx  = {2'b00, q_wx[16:0]};
	assign wmy  = {2'b00, q_wy[16:0]};
	assign wx   = div_line_s[NS-1].neg_x ? -wmx : wmx;
	assign wy   = div_line_s[NS-1].neg_y ? -wmy : wmy;
	assign fa_c = $signed({1'b0, q_fa});
	assign fb_c = $signed({1'b0, q_fb});
	assign pax_c = fa_c * wx;
	assign pay_c = fa_c * wy;
	assign pbx_c = fb_c * wx;
	assign pby_c = fb_c * wy;

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s6 <= div_line_s[NS-1];
			pax_s6   <= pax_c;
			pay_s6   <= pay_c;
			pbx_s6   <= pbx_c;
			pby_s6   <= pby_c;
		end
	end

	// stage 7: new velocities
	always_comb begin
		cr7_c        = carry_s6;
		cr7_c.nv_a_x = dcr_pkg::sat16(64'(carry_s6.pr.a_vel_x)
			+ dcr_pkg::rnd_shr(64'(pax_s6), 30));
		cr7_c.nv_a_y = dcr_pkg::sat16(64'(carry_s6.pr.a_vel_y)
			+ dcr_pkg::rnd_shr(64'(pay_s6), 30));
		cr7_c.nv_b_x = dcr_pkg::sat16(64'(carry_s6.pr.b_vel_x)
			- dcr_pkg::rnd_shr(64'(pbx_s6), 30));
		cr7_c.nv_b_y = dcr_pkg::sat16(64'(carry_s6.pr.b_vel_y)
			- dcr_pkg::rnd_shr(64'(pby_s6), 30));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s7 <= cr7_c;
		end
	end

	// stage 8: relative displacement over one step
	assign dvx_c = 17'(carry_s7.nv_a_x) - 17'(carry_s7.nv_b_x);
	assign dvy_c = 17'(carry_s7.nv_a_y) - 17'(carry_s7.nv_b_y);
	assign tx_c  = dvx_c * dts;
	assign ty_c  = dvy_c * dts;

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s8 <= carry_s7;
			tx_s8    <= tx_c;
			ty_s8    <= ty_c;
		end
	end

	// stage 9: predicted separation
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s9 <= carry_s8;
			sepx_s9  <= 19'(carry_s8.pr.a_pos_x) - 19'(carry_s8.pr.b_pos_x)
				+ 19'(dcr_pkg::rnd_shr(64'(tx_s8), 16));
			sepy_s9  <= 19'(carry_s8.pr.a_pos_y) - 19'(carry_s8.pr.b_pos_y)
				+ 19'(dcr_pkg::rnd_shr(64'(ty_s8), 16));
		end
	end

	// stage 10: squared lengths
	assign sx2_c = sepx_s9 * sepx_s9;
	assign sy2_c = sepy_s9 * sepy_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s10 <= carry_s9;
			sx2_s10   <= sx2_c[36:0];
			sy2_s10   <= sy2_c[36:0];
			c2_s10    <= carry_s9.pr.contact_dist * carry_s9.pr.contact_dist;
		end
	end

	// stage 11: overlap test and output selection
	assign back = !carry_s10.coin && ((38'(sx2_s10) + 38'(sy2_s10)) < 38'(c2_s10));

	always_ff @(posedge clk) begin
		if (en) begin
			resp_s11.new_a_vel_x  <= carry_s10.coin ? carry_s10.pr.a_vel_x : carry_s10.nv_a_x;
			resp_s11.new_a_vel_y  <= carry_s10.coin ? carry_s10.pr.a_vel_y : carry_s10.nv_a_y;
			resp_s11.new_b_vel_x  <= carry_s10.coin ? carry_s10.pr.b_vel_x : carry_s10.nv_b_x;
			resp_s11.new_b_vel_y  <= carry_s10.coin ? carry_s10.pr.b_vel_y : carry_s10.nv_b_y;
			resp_s11.new_a_pos_x  <= back ? carry_s10.sb_a_x : carry_s10.pr.a_pos_x;
			resp_s11.new_a_pos_y  <= back ? carry_s10.sb_a_y : carry_s10.pr.a_pos_y;
			resp_s11.new_b_pos_x  <= back ? carry_s10.sb_b_x : carry_s10.pr.b_pos_x;
			resp_s11.new_b_pos_y  <= back ? carry_s10.sb_b_y : carry_s10.pr.b_pos_y;
			resp_s11.stepped_back <= back;
			resp_s11.coincident   <= carry_s10.coin;
		end
	end

endmodule
